FILE: rtl/vnr_pkg.sv
// ----------------------------------------------------------------------------
// vnr_pkg
// Shared types and codes for the vector reciprocal-norm block.
// ----------------------------------------------------------------------------
package vnr_pkg;

    localparam int WEIGHT_W = 16;
    localparam int NORM_W   = 32;
    localparam int TOTAL_W  = 48;

    typedef logic signed [WEIGHT_W-1:0] weight_t;
    typedef logic signed [NORM_W-1:0]   norm_t;
    typedef logic signed [TOTAL_W-1:0]  total_t;
    typedef logic        [1:0]          status_t;

    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_EMPTY = 2'd1;
    localparam status_t STATUS_ZERO  = 2'd2;

    localparam logic MODE_EUCLID = 1'b0;
    localparam logic MODE_SUM    = 1'b1;

endpackage

FILE: rtl/vnr_if.sv
// ----------------------------------------------------------------------------
// vnr_if
// Valid/ready channels for weight items and normalizer results.
// ----------------------------------------------------------------------------
interface vnr_in_if;
    import vnr_pkg::*;

    logic    valid;
    logic    ready;
    weight_t weight_value;
    logic    has_entry;
    logic    last_of_vector;

    modport source (output valid, output weight_value, output has_entry,
                    output last_of_vector, input ready);
    modport sink   (input valid, input weight_value, input has_entry,
                    input last_of_vector, output ready);
endinterface

interface vnr_out_if;
    import vnr_pkg::*;

    logic    valid;
    logic    ready;
    norm_t   normalizer;
    status_t status;

    modport source (output valid, output normalizer, output status, input ready);
    modport sink   (input valid, input normalizer, input status, output ready);
endinterface

FILE: rtl/vector_norm_reciprocal.sv
// ----------------------------------------------------------------------------
// vector_norm_reciprocal
// Accumulates a weight vector (sum of squares or plain sum) and returns
// 1/sqrt(total) or 1/total in Q8.24 through one shared subtractor.
// ----------------------------------------------------------------------------
//  channel   | dir | payload                                   | handshake
//  ----------+-----+-------------------------------------------+-----------
//  weights   | in  | weight_value, has_entry, last_of_vector   | valid/ready
//  result    | out | normalizer, status                        | valid/ready
//  cfg       | in  | cfg_wr_data (norm_mode)                   | cfg_wr_en
//
// An item without the last mark is handled in the accumulate state. A last
// item is accumulated, then passes a setup step, 49 restoring-division steps,
// 25 square-root steps in Euclidean mode, and a step that loads the output
// register; an empty, zero or, in Euclidean mode, negative total skips to it.
// The division and the square root share one 50-bit subtractor. The output
// register frees the sequencer once loaded; a stalled result holds the block
// in its final step. Reset clears the total, the mode and all control state.
// ----------------------------------------------------------------------------
module vector_norm_reciprocal (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic          cfg_wr_data,
    vnr_in_if.sink        weights,
    vnr_out_if.source     result
);
    import vnr_pkg::*;

    localparam logic [2:0] S_ACC   = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_SQRT  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    localparam int QW = TOTAL_W + 1;
    localparam logic [QW-1:0] ONE_EUCLID = {1'b1, {(QW-1){1'b0}}};
    localparam logic [QW-1:0] ONE_SUM    = {{(QW-25){1'b0}}, 1'b1, 24'd0};
    localparam logic [5:0]    DIV_STEPS  = 6'(QW - 1);

    logic [2:0]    state_reg, state_next;
    logic          mode_reg;
    total_t        total_reg, total_next;
    logic          seen_reg, seen_next;
    logic [TOTAL_W-1:0] div_reg, div_next;
    logic [QW-1:0] rem_reg, rem_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic [QW-1:0] bit_reg, bit_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic          neg_reg, neg_next;
    status_t       stat_reg, stat_next;
    logic          out_valid_reg, out_valid_next;
    norm_t         out_norm_reg, out_norm_next;
    status_t       out_stat_reg, out_stat_next;

    // shared subtractor
    logic [QW:0]   sub_a, sub_b, sub_diff;
    logic          sub_ge;

    logic          accept;
    logic signed [2*WEIGHT_W-1:0] square;
    logic signed [TOTAL_W:0]      incr, sum;
    total_t        sat_sum;
    logic [QW-1:0] trial;

    assign accept       = weights.valid && weights.ready;
    assign weights.ready = (state_reg == S_ACC);

    assign result.valid      = out_valid_reg;
    assign result.normalizer = out_norm_reg;
    assign result.status     = out_stat_reg;

    assign square = weights.weight_value * weights.weight_value;

    always_comb
    begin
        if (mode_reg == MODE_EUCLID)
        begin
            incr = (TOTAL_W+1)'(square);
        end
        else
        begin
            incr = (TOTAL_W+1)'(weights.weight_value);
        end
        sum = {total_reg[TOTAL_W-1], total_reg} + incr;
        if (sum[TOTAL_W] != sum[TOTAL_W-1])
        begin
            sat_sum = sum[TOTAL_W] ? {1'b1, {(TOTAL_W-1){1'b0}}}
                                   : {1'b0, {(TOTAL_W-1){1'b1}}};
        end
        else
        begin
            sat_sum = sum[TOTAL_W-1:0];
        end
    end

    assign trial = {rem_reg[TOTAL_W-1:0], quo_reg[QW-1]};

    always_comb
    begin
        if (state_reg == S_SQRT)
        begin
            sub_a = {1'b0, rem_reg};
            sub_b = {1'b0, quo_reg + bit_reg};
        end
        else
        begin
            sub_a = {1'b0, trial};
            sub_b = {2'b00, div_reg};
        end
        sub_diff = sub_a - sub_b;
        sub_ge   = !sub_diff[QW];
    end

    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        seen_next      = seen_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        bit_next       = bit_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;
        stat_next      = stat_reg;
        out_valid_next = out_valid_reg;
        out_norm_next  = out_norm_reg;
        out_stat_next  = out_stat_reg;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_ACC:
            begin
                if (accept)
                begin
                    if (weights.has_entry)
                    begin
                        total_next = sat_sum;
                        seen_next  = 1'b1;
                    end
                    if (weights.last_of_vector)
                    begin
                        state_next = S_SETUP;
                    end
                end
            end
            S_SETUP:
            begin
                total_next = '0;
                seen_next  = 1'b0;
                rem_next   = '0;
                cnt_next   = DIV_STEPS;
                neg_next   = 1'b0;
                stat_next  = STATUS_OK;
                quo_next   = '0;
                state_next = S_DONE;
                if (!seen_reg)
                begin
                    stat_next = STATUS_EMPTY;
                end
                else if (total_reg == '0)
                begin
                    stat_next = STATUS_ZERO;
                end
                else if (mode_reg == MODE_EUCLID)
                begin
                    if (total_reg[TOTAL_W-1])
                    begin
                        stat_next = STATUS_ZERO;
                    end
                    else
                    begin
                        div_next   = total_reg;
                        quo_next   = ONE_EUCLID;
                        state_next = S_DIV;
                    end
                end
                else
                begin
                    neg_next   = total_reg[TOTAL_W-1];
                    div_next   = total_reg[TOTAL_W-1] ? -total_reg : total_reg;
                    quo_next   = ONE_SUM;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // shift numerator out at the top, quotient bits in at the bottom
                rem_next = sub_ge ? sub_diff[QW-1:0] : trial;
                quo_next = {quo_reg[QW-2:0], sub_ge};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == '0)
                begin
                    if (mode_reg == MODE_EUCLID)
                    begin
                        rem_next   = {quo_reg[QW-2:0], sub_ge};
                        quo_next   = '0;
                        bit_next   = ONE_EUCLID;
                        state_next = S_SQRT;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SQRT:
            begin
                rem_next = sub_ge ? sub_diff[QW-1:0] : rem_reg;
                quo_next = (quo_reg >> 1) + (sub_ge ? bit_reg : '0);
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_norm_next  = neg_reg ? -quo_reg[NORM_W-1:0]
                                             : quo_reg[NORM_W-1:0];
                    out_stat_next  = stat_reg;
                    state_next     = S_ACC;
                end
            end
            default:
            begin
                state_next = S_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_ACC;
            mode_reg      <= MODE_EUCLID;
            total_reg     <= '0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg      <= div_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        bit_reg      <= bit_next;
        cnt_reg      <= cnt_next;
        neg_reg      <= neg_next;
        stat_reg     <= stat_next;
        out_norm_reg <= out_norm_next;
        out_stat_reg <= out_stat_next;
    end

endmodule

FILE: rtl/vnr_checker.sv
// ----------------------------------------------------------------------------
// vnr_checker
// Port-level checks for the vector reciprocal-norm block.
// ----------------------------------------------------------------------------
module vnr_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            in_last,
    input logic            out_valid,
    input logic            out_ready,
    input vnr_pkg::norm_t   out_normalizer,
    input vnr_pkg::status_t out_status
);
    import vnr_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_normalizer)
                                    && $stable(out_status))
        else $error("result changed while stalled");

    // empty or zero vectors report a zero normalizer
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status != STATUS_OK |-> out_normalizer == '0)
        else $error("nonzero normalizer with error status");

    // a non-final transfer keeps the input open
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !in_last |=> in_ready)
        else $error("input closed after a non-final transfer");

    // a final transfer starts the computation
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("input still open after a final transfer");

    // a new result appears only at the end of a computation
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a computation");

endmodule

bind vector_norm_reciprocal vnr_checker u_vnr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (weights.valid),
    .in_ready       (weights.ready),
    .in_last        (weights.last_of_vector),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .out_normalizer (result.normalizer),
    .out_status     (result.status)
);
